[design/wsdfr_pkg.sv]
package wsdfr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  // Frame kind codes on the result channel
  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_BINARY = 3'd1;
  localparam logic [2:0] KIND_CLOSE  = 3'd2;
  localparam logic [2:0] KIND_PING   = 3'd3;
  localparam logic [2:0] KIND_PONG   = 3'd4;
  localparam logic [2:0] KIND_OTHER  = 3'd5;

  // Opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [6:0]  LEN_EXT64     = 7'd127;
  localparam logic [2:0]  EXT16_COUNT   = 3'd1;
  localparam logic [2:0]  EXT64_COUNT   = 3'd7;
  localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 4;
  localparam logic        REG_MAX_LEN = 1'b0;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [2:0]  frame_kind;
    logic        final_fragment;
    logic        last_in_frame;
    logic [15:0] close_code;
    logic        length_error;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    case (op)
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_CLOSE:  k = KIND_CLOSE;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

[design/websocket_frame_deframer.sv]
// A payload, marker or error result appears on the output register in the
// cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle; the output register holds a result
// while the next byte is taken, so only a stalled output slows the input.
// Reset (async, active low) returns the parser to the first header byte,
// clears the closed state and sets the maximum payload length to all ones.
module websocket_frame_deframer
  import wsdfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        payload_byte_o,
  output logic              has_byte_o,
  output logic [2:0]        frame_kind_o,
  output logic              final_fragment_o,
  output logic              last_in_frame_o,
  output logic [15:0]       close_code_o,
  output logic              length_error_o
);

  logic [63:0] max_len;
  logic        fire;
  logic        res_valid;
  result_t     res;
  result_t     out;

  assign fire = rx_valid_i & rx_ready_o;

  wsdfr_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  wsdfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsdfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .in_ready_o  (rx_ready_o),
    .out_valid_o (out_valid_o),
    .out_o       (out)
  );

  assign payload_byte_o   = out.payload_byte;
  assign has_byte_o       = out.has_byte;
  assign frame_kind_o     = out.frame_kind;
  assign final_fragment_o = out.final_fragment;
  assign last_in_frame_o  = out.last_in_frame;
  assign close_code_o     = out.close_code;
  assign length_error_o   = out.length_error;

endmodule

[design/wsdfr_apb_regs.sv]
module wsdfr_apb_regs
  import wsdfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [63:0]       max_len_o
);

  logic [63:0] max_len_q;
  logic        wr_en;
  logic        sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[CFG_AW-1] == REG_MAX_LEN);
  assign wr_en   = psel & penable & pwrite & sel_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
    end else if (wr_en) begin
      max_len_q <= pwdata;
    end
  end

  assign prdata    = sel_max ? max_len_q : '0;
  assign max_len_o = max_len_q;

endmodule

[design/wsdfr_parser.sv]
module wsdfr_parser
  import wsdfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [63:0] max_len_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_pos_q, key_pos_d;
  logic [1:0]  pay_pos_q, pay_pos_d;
  logic [15:0] cap_q, cap_d;
  logic        closed_q, closed_d;

  logic [6:0]  len7;
  logic [63:0] ext_len;
  logic [63:0] hdr_len;
  logic        hdr_err;
  logic        hdr_zero;
  logic        hdr_done;
  logic [7:0]  key_byte;
  logic [7:0]  data_byte;
  logic [15:0] data_cap;
  logic [1:0]  data_pos;
  logic [63:0] rem_dec;
  logic        data_last;
  logic [2:0]  kind;
  logic        is_close;

  assign len7     = rx_byte_i[6:0];
  assign ext_len  = {rem_q[55:0], rx_byte_i};
  assign kind     = kind_of(opcode_q);
  assign is_close = (kind == KIND_CLOSE);

  // Length seen when the header completes, by phase
  always_comb begin
    case (phase_q)
      PH_HDR1: hdr_len = {57'd0, len7};
      PH_EXT:  hdr_len = ext_len;
      default: hdr_len = rem_q;
    endcase
  end

  assign hdr_err  = (hdr_len > max_len_i);
  assign hdr_zero = (hdr_len == 64'd0);

  always_comb begin
    case (phase_q)
      PH_HDR1: hdr_done = (len7 != LEN_EXT16) && (len7 != LEN_EXT64) && !rx_byte_i[7];
      PH_EXT:  hdr_done = (ext_cnt_q == 3'd0) && !mask_q;
      PH_KEY:  hdr_done = (key_pos_q == 2'd3);
      default: hdr_done = 1'b0;
    endcase
  end

  always_comb begin
    case (key_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data_byte = rx_byte_i ^ (mask_q ? key_byte : 8'h00);
  assign rem_dec   = rem_q - 64'd1;
  assign data_last = (rem_dec == 64'd0);

  // Capture the first two payload bytes as a big-endian close status
  always_comb begin
    case (pay_pos_q)
      2'd0: begin
        data_cap = {data_byte, 8'h00};
        data_pos = 2'd1;
      end
      2'd1: begin
        data_cap = {cap_q[15:8], data_byte};
        data_pos = 2'd2;
      end
      default: begin
        data_cap = cap_q;
        data_pos = pay_pos_q;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    ext_cnt_d = ext_cnt_q;
    rem_d     = rem_q;
    key_d     = key_q;
    key_pos_d = key_pos_q;
    pay_pos_d = pay_pos_q;
    cap_d     = cap_q;
    closed_d  = closed_q;
    if (fire_i && !closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d    = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = rx_byte_i[7];
          rem_d  = {57'd0, len7};
          if (len7 == LEN_EXT16) begin
            rem_d     = '0;
            ext_cnt_d = EXT16_COUNT;
            phase_d   = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            rem_d     = '0;
            ext_cnt_d = EXT64_COUNT;
            phase_d   = PH_EXT;
          end else if (rx_byte_i[7]) begin
            key_pos_d = 2'd0;
            key_d     = '0;
            phase_d   = PH_KEY;
          end
        end
        PH_EXT: begin
          rem_d = ext_len;
          if (ext_cnt_q != 3'd0) begin
            ext_cnt_d = ext_cnt_q - 3'd1;
          end else if (mask_q) begin
            key_pos_d = 2'd0;
            key_d     = '0;
            phase_d   = PH_KEY;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (key_pos_q != 2'd3) begin
            key_pos_d = key_pos_q + 2'd1;
          end
        end
        PH_DATA: begin
          key_pos_d = key_pos_q + 2'd1;
          cap_d     = data_cap;
          pay_pos_d = data_pos;
          rem_d     = rem_dec;
          if (data_last) begin
            phase_d = PH_HDR0;
            if (is_close) begin
              closed_d = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
      if (hdr_done) begin
        key_pos_d = 2'd0;
        pay_pos_d = 2'd0;
        cap_d     = CLOSE_DEFAULT;
        if (hdr_err) begin
          closed_d = 1'b1;
          phase_d  = PH_HDR0;
        end else if (hdr_zero) begin
          phase_d = PH_HDR0;
          if (is_close) begin
            closed_d = 1'b1;
          end
        end else begin
          phase_d = PH_DATA;
        end
      end
    end
  end

  // Result
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.payload_byte   = 8'h00;
    res_o.has_byte       = 1'b0;
    res_o.frame_kind     = kind;
    res_o.final_fragment = fin_q;
    res_o.last_in_frame  = 1'b0;
    res_o.close_code     = 16'd0;
    res_o.length_error   = 1'b0;
    if (fire_i && !closed_q) begin
      if (hdr_done) begin
        res_valid_o         = hdr_err || hdr_zero;
        res_o.last_in_frame = 1'b1;
        if (hdr_err) begin
          res_o.length_error = 1'b1;
        end else if (is_close) begin
          res_o.close_code = CLOSE_DEFAULT;
        end
      end else if (phase_q == PH_DATA) begin
        res_valid_o         = 1'b1;
        res_o.payload_byte  = data_byte;
        res_o.has_byte      = 1'b1;
        res_o.last_in_frame = data_last;
        if (data_last && is_close) begin
          res_o.close_code = (data_pos == 2'd2) ? data_cap : CLOSE_DEFAULT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= 4'h0;
      fin_q     <= 1'b0;
      mask_q    <= 1'b0;
      ext_cnt_q <= 3'd0;
      rem_q     <= '0;
      key_q     <= '0;
      key_pos_q <= 2'd0;
      pay_pos_q <= 2'd0;
      cap_q     <= CLOSE_DEFAULT;
      closed_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      fin_q     <= fin_d;
      mask_q    <= mask_d;
      ext_cnt_q <= ext_cnt_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      key_pos_q <= key_pos_d;
      pay_pos_q <= pay_pos_d;
      cap_q     <= cap_d;
      closed_q  <= closed_d;
    end
  end

endmodule

[design/wsdfr_out_reg.sv]
module wsdfr_out_reg
  import wsdfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // Accept a new byte whenever the held result leaves this cycle or none is held
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import wsdfr_pkg::*;

  localparam logic [3:0]        OP_CONT        = 4'h0;
  localparam logic [3:0]        OP_RESERVED_HI = 4'hF;
  localparam logic [CFG_AW-1:0] MAX_LEN_ADDR   = CFG_AW'(8 * REG_MAX_LEN);

  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_e;
  typedef enum int {END_CLOSE_EMPTY, END_CLOSE_ONE, END_CLOSE_CODE, END_LENGTH_ERROR} ending_e;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [CFG_AW-1:0] paddr       = '0;
  logic [CFG_DW-1:0] pwdata      = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              rx_valid_i  = 1'b0;
  logic              rx_ready_o;
  logic [7:0]        rx_byte_i   = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        payload_byte_o;
  logic              has_byte_o;
  logic [2:0]        frame_kind_o;
  logic              final_fragment_o;
  logic              last_in_frame_o;
  logic [15:0]       close_code_o;
  logic              length_error_o;

  websocket_frame_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .has_byte_o      (has_byte_o),
    .frame_kind_o    (frame_kind_o),
    .final_fragment_o(final_fragment_o),
    .last_in_frame_o (last_in_frame_o),
    .close_code_o    (close_code_o),
    .length_error_o  (length_error_o)
  );

  // Bytes waiting to be sent and deframed results still to arrive
  logic [7:0] rx_stream[$];
  result_t    deframed_q[$];
  int         bytes_queued   = 0;
  int         bytes_accepted = 0;
  int         mismatch_count = 0;

  // Parser copy kept by the testbench
  logic [63:0] max_len_cfg = '1;
  phase_e      prs_phase   = PH_HDR0;
  logic [3:0]  hdr_op      = 4'h0;
  logic        hdr_fin     = 1'b0;
  logic        hdr_mask    = 1'b0;
  logic [2:0]  ext_left    = 3'd0;
  logic [63:0] len_left    = '0;
  logic [31:0] mask_key    = '0;
  logic [1:0]  key_idx     = 2'd0;
  logic [1:0]  pay_idx     = 2'd0;
  logic [15:0] close_cap   = CLOSE_DEFAULT;
  logic        halted      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [2:0] kind_from(input logic [3:0] op);
    case (op)
      OP_TEXT:   return KIND_TEXT;
      OP_BINARY: return KIND_BINARY;
      OP_CLOSE:  return KIND_CLOSE;
      OP_PING:   return KIND_PING;
      OP_PONG:   return KIND_PONG;
      default:   return KIND_OTHER;
    endcase
  endfunction

  function automatic logic [15:0] closing_code();
    if (kind_from(hdr_op) != KIND_CLOSE) return 16'd0;
    return (pay_idx >= 2'd2) ? close_cap : CLOSE_DEFAULT;
  endfunction

  task automatic expect_result(input logic [7:0] d, input logic has, input logic last,
                               input logic [15:0] code, input logic err);
    result_t r;
    r.payload_byte   = d;
    r.has_byte       = has;
    r.frame_kind     = kind_from(hdr_op);
    r.final_fragment = hdr_fin;
    r.last_in_frame  = last;
    r.close_code     = code;
    r.length_error   = err;
    deframed_q.push_back(r);
  endtask

  task automatic close_out_frame();
    if (kind_from(hdr_op) == KIND_CLOSE) halted = 1'b1;
    prs_phase = PH_HDR0;
  endtask

  task automatic header_complete();
    key_idx   = 2'd0;
    pay_idx   = 2'd0;
    close_cap = CLOSE_DEFAULT;
    if (len_left > max_len_cfg) begin
      expect_result(8'h00, 1'b0, 1'b1, 16'd0, 1'b1);
      halted    = 1'b1;
      prs_phase = PH_HDR0;
    end else if (len_left == 64'd0) begin
      expect_result(8'h00, 1'b0, 1'b1, closing_code(), 1'b0);
      close_out_frame();
    end else begin
      prs_phase = PH_DATA;
    end
  endtask

  task automatic length_complete();
    if (hdr_mask) begin
      key_idx   = 2'd0;
      mask_key  = '0;
      prs_phase = PH_KEY;
    end else begin
      header_complete();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] d;
    if (halted) return;
    case (prs_phase)
      PH_HDR0: begin
        hdr_fin   = b[7];
        hdr_op    = b[3:0];
        prs_phase = PH_HDR1;
      end
      PH_HDR1: begin
        hdr_mask = b[7];
        len_left = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_left  = EXT16_COUNT;
          prs_phase = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left  = EXT64_COUNT;
          prs_phase = PH_EXT;
        end else begin
          len_left = 64'(b[6:0]);
          length_complete();
        end
      end
      PH_EXT: begin
        len_left = {len_left[55:0], b};
        if (ext_left == 3'd0) length_complete();
        else ext_left = ext_left - 3'd1;
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (key_idx == 2'd3) header_complete();
        else key_idx = key_idx + 2'd1;
      end
      PH_DATA: begin
        d = hdr_mask ? (b ^ mask_key[8*(3-key_idx) +: 8]) : b;
        key_idx = key_idx + 2'd1;
        if (pay_idx == 2'd0) begin
          close_cap = {d, 8'h00};
          pay_idx   = 2'd1;
        end else if (pay_idx == 2'd1) begin
          close_cap[7:0] = d;
          pay_idx        = 2'd2;
        end
        len_left = len_left - 64'd1;
        if (len_left == 64'd0) begin
          expect_result(d, 1'b1, 1'b1, closing_code(), 1'b0);
          close_out_frame();
        end else begin
          expect_result(d, 1'b1, 1'b0, 16'd0, 1'b0);
        end
      end
      default: prs_phase = PH_HDR0;
    endcase
  endtask

  // Sender: record each transaction at the rising edge, drive at the falling edge
  logic rx_taken   = 1'b0;
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(posedge clk_i) begin
    rx_taken = rst_ni && rx_valid_i && rx_ready_o;
    if (rx_taken) begin
      deframe_byte(rx_byte_i);
      bytes_accepted++;
    end
  end

  always @(negedge clk_i) begin
    if (rx_valid_i && !rx_taken) begin
      // hold the offered byte
    end else if (gap_left != 0) begin
      rx_valid_i <= 1'b0;
      gap_left--;
    end else if (rx_stream.size() != 0) begin
      rx_byte_i  <= rx_stream.pop_front();
      rx_valid_i <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      rx_valid_i <= 1'b0;
    end
  end

  // Receiver: stall pattern is redrawn at random, one long hold-off mid-run
  int  ready_cycle    = 0;
  int  stall_mode     = 0;
  int  hold_left      = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    ready_cycle++;
    if (ready_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && bytes_accepted >= 350) begin
      long_hold_done = 1'b1;
      hold_left      = 160;
      out_ready_i   <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deframed_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result at %0t: byte=%h has=%b kind=%0d last=%b err=%b",
                   $time, payload_byte_o, has_byte_o, frame_kind_o, last_in_frame_o,
                   length_error_o);
        mismatch_count++;
      end else begin
        want = deframed_q.pop_front();
        if (payload_byte_o !== want.payload_byte || has_byte_o !== want.has_byte ||
            frame_kind_o !== want.frame_kind || final_fragment_o !== want.final_fragment ||
            last_in_frame_o !== want.last_in_frame || close_code_o !== want.close_code ||
            length_error_o !== want.length_error) begin
          if (mismatch_count < 10) begin
            $display("mismatch at %0t: expected byte=%h has=%b kind=%0d fin=%b last=%b code=%0d err=%b",
                     $time, want.payload_byte, want.has_byte, want.frame_kind,
                     want.final_fragment, want.last_in_frame, want.close_code,
                     want.length_error);
            $display("               actual   byte=%h has=%b kind=%0d fin=%b last=%b code=%0d err=%b",
                     payload_byte_o, has_byte_o, frame_kind_o, final_fragment_o,
                     last_in_frame_o, close_code_o, length_error_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] first, input logic masked, input len_form_e form,
                             input logic [63:0] len, input int n_data);
    logic [31:0] key;
    key = $urandom;
    put_byte(first);
    case (form)
      LEN_SHORT: put_byte({masked, len[6:0]});
      LEN_16: begin
        put_byte({masked, LEN_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
    repeat (n_data) put_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic len_form_e pick_form(input int unsigned len);
    if (len > 125) return ($urandom_range(0, 1) != 0) ? LEN_16 : LEN_64;
    case ($urandom_range(0, 5))
      0:       return LEN_16;
      1:       return LEN_64;
      default: return LEN_SHORT;
    endcase
  endfunction

  // Any frame but a close; length never above cap
  task automatic queue_random_frame(input logic [63:0] cap);
    logic [3:0]  op;
    int unsigned lim;
    int unsigned len;
    int          r;
    case ($urandom_range(0, 5))
      0: op = OP_TEXT;
      1: op = OP_BINARY;
      2: op = OP_PING;
      3: op = OP_PONG;
      4: op = OP_CONT;
      default: begin
        do op = 4'($urandom); while (op == OP_CLOSE);
      end
    endcase
    lim = (cap > 64'd150) ? 150 : int'(cap);
    r   = $urandom_range(0, 15);
    if (r == 0) len = lim;
    else if (r < 3) len = $urandom_range(0, lim);
    else len = $urandom_range(0, (lim < 12) ? lim : 12);
    queue_frame({1'($urandom), 3'($urandom), op}, 1'($urandom), pick_form(len), 64'(len), len);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (rx_stream.size() != 0 || rx_valid_i || deframed_q.size() != 0);
    // header bytes give no result; let any last one settle
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_len_cfg = value;
  endtask

  initial begin
    int unsigned cap;
    ending_e     ending;
    logic [7:0]  first;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty text, masked unfinished binary, pong via 16-bit length, all-ones headers
    queue_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, LEN_SHORT, 64'd0, 0);
    queue_frame({1'b0, 3'b000, OP_BINARY}, 1'b1, LEN_SHORT, 64'd1, 1);
    queue_frame({1'b1, 3'b000, OP_PONG}, 1'b0, LEN_16, 64'd1, 1);
    queue_frame({1'b1, 3'b111, OP_RESERVED_HI}, 1'b1, LEN_64, 64'd0, 0);
    wait_idle();

    write_max_len('1);
    while (bytes_queued < 280) queue_random_frame('1);
    wait_idle();

    // zero limit: only empty frames get through
    write_max_len('0);
    while (bytes_queued < 330) queue_random_frame('0);
    wait_idle();

    cap = $urandom_range(1, 30);
    write_max_len(64'(cap));
    while (bytes_queued < 560) queue_random_frame(64'(cap));
    wait_idle();

    cap = $urandom_range(40, 200);
    write_max_len(64'(cap));
    while (bytes_queued < 630) queue_random_frame(64'(cap));
    wait_idle();
    while (bytes_queued < 700) queue_random_frame(64'(cap));
    wait_idle();

    // a close or a length error stops the parser for good, so it comes last
    ending = ending_e'($urandom_range(0, 3));
    first  = {1'($urandom), 3'($urandom), OP_CLOSE};
    case (ending)
      END_CLOSE_EMPTY: queue_frame(first, 1'($urandom), pick_form(0), 64'd0, 0);
      END_CLOSE_ONE:   queue_frame(first, 1'($urandom), pick_form(1), 64'd1, 1);
      END_CLOSE_CODE: begin
        cap = $urandom_range(2, 12);
        queue_frame(first, 1'($urandom), pick_form(cap), 64'(cap), cap);
      end
      default: begin
        cap = $urandom_range(0, 100);
        write_max_len(64'(cap));
        first[3:0] = 4'($urandom);
        if ($urandom_range(0, 1) != 0)
          queue_frame(first, 1'($urandom), LEN_SHORT, 64'($urandom_range(cap + 1, 125)), 0);
        else
          queue_frame(first, 1'($urandom), LEN_64, {1'b1, 31'($urandom), 32'($urandom)}, 0);
      end
    endcase
    // these must all be dropped
    repeat (12) put_byte(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (20) @(negedge clk_i);

    if (mismatch_count == 0 && deframed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/wsdfr_pkg.sv
design/wsdfr_apb_regs.sv
design/wsdfr_parser.sv
design/wsdfr_out_reg.sv
design/websocket_frame_deframer.sv
tb/tb.sv
